/* rtl/core/assert_macros.svh */
// Assertion macros shared by the lexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is asserted.
`define SLX_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, active on every rising clock edge.
`define SLX_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/slx_pkg.sv */
// Shared types, character codes and token kinds for the source byte lexer.
package slx_pkg;

    typedef logic [5:0]  kind_t;
    typedef logic [15:0] len_t;
    typedef logic [15:0] offset_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        kind_t   tok_kind;
        offset_t start_offset;
        len_t    token_length;
        logic    last_token;
    } out_word_t;

    // One-hot lexer modes.
    typedef enum logic [13:0] {
        MODE_IDLE    = 14'b00000000000001,
        MODE_IDENT   = 14'b00000000000010,
        MODE_INT     = 14'b00000000000100,
        MODE_REAL    = 14'b00000000001000,
        MODE_DOT     = 14'b00000000010000,
        MODE_SLASH   = 14'b00000000100000,
        MODE_COMMENT = 14'b00000001000000,
        MODE_AMP     = 14'b00000010000000,
        MODE_PIPE    = 14'b00000100000000,
        MODE_BANG    = 14'b00001000000000,
        MODE_EQ      = 14'b00010000000000,
        MODE_LESS    = 14'b00100000000000,
        MODE_GREATER = 14'b01000000000000,
        MODE_FIXED   = 14'b10000000000000
    } lex_mode_t;

    // Per-byte decision from the classifier.
    typedef struct packed {
        logic      absorb;
        logic      close;
        lex_mode_t mode;
        kind_t     kind;
    } slx_step_t;

    // Token queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    typedef logic [Q_PTR_W-1:0] qptr_t;
    typedef logic [Q_PTR_W:0]   qcnt_t;

    localparam len_t LEN_MAX = 16'hFFFF;

    // Characters.
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_PIPE       = 8'h7C;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_TILDE      = 8'h7E;

    // Token kinds.
    localparam kind_t K_IDENT     = 6'd0;
    localparam kind_t K_INT       = 6'd1;
    localparam kind_t K_REAL      = 6'd2;
    localparam kind_t K_COMMENT   = 6'd3;
    localparam kind_t K_DOT       = 6'd4;
    localparam kind_t K_SLASH     = 6'd5;
    localparam kind_t K_LPAREN    = 6'd6;
    localparam kind_t K_RPAREN    = 6'd7;
    localparam kind_t K_LBRACKET  = 6'd8;
    localparam kind_t K_RBRACKET  = 6'd9;
    localparam kind_t K_LBRACE    = 6'd10;
    localparam kind_t K_RBRACE    = 6'd11;
    localparam kind_t K_COMMA     = 6'd12;
    localparam kind_t K_SPACE     = 6'd13;
    localparam kind_t K_NEWLINE   = 6'd14;
    localparam kind_t K_TAB       = 6'd15;
    localparam kind_t K_SEMI      = 6'd16;
    localparam kind_t K_DAMP      = 6'd17;
    localparam kind_t K_AMP       = 6'd18;
    localparam kind_t K_DPIPE     = 6'd19;
    localparam kind_t K_PIPE      = 6'd20;
    localparam kind_t K_MINUS     = 6'd21;
    localparam kind_t K_BANGEQ    = 6'd22;
    localparam kind_t K_BANG      = 6'd23;
    localparam kind_t K_STAR      = 6'd24;
    localparam kind_t K_PERCENT   = 6'd25;
    localparam kind_t K_PLUS      = 6'd26;
    localparam kind_t K_DEQ       = 6'd27;
    localparam kind_t K_EQ        = 6'd28;
    localparam kind_t K_LE        = 6'd29;
    localparam kind_t K_LT        = 6'd30;
    localparam kind_t K_GE        = 6'd31;
    localparam kind_t K_GT        = 6'd32;
    localparam kind_t K_COLON     = 6'd33;
    localparam kind_t K_TILDE     = 6'd34;
    localparam kind_t K_INVALID   = 6'd35;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Kind of a byte that always stands alone.
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            CH_LPAREN:   k = K_LPAREN;
            CH_RPAREN:   k = K_RPAREN;
            CH_LBRACKET: k = K_LBRACKET;
            CH_RBRACKET: k = K_RBRACKET;
            CH_LBRACE:   k = K_LBRACE;
            CH_RBRACE:   k = K_RBRACE;
            CH_COMMA:    k = K_COMMA;
            CH_SPACE:    k = K_SPACE;
            CH_NEWLINE:  k = K_NEWLINE;
            CH_TAB:      k = K_TAB;
            CH_SEMI:     k = K_SEMI;
            CH_MINUS:    k = K_MINUS;
            CH_STAR:     k = K_STAR;
            CH_PERCENT:  k = K_PERCENT;
            CH_PLUS:     k = K_PLUS;
            CH_COLON:    k = K_COLON;
            CH_TILDE:    k = K_TILDE;
            default:     k = K_INVALID;
        endcase
        return k;
    endfunction

endpackage

/* rtl/core/source_byte_lexer.sv */
// Top level of the source byte lexer: longest-match tokenizer, one byte per word.
// Throughput: one input word per cycle, one token word out per cycle; s_ready drops while
//   the token queue holds more than two words (result-side stall, or final bytes that each
//   push two tokens back to back).
// Latency: a token reaches m_* the cycle after its closing or flushing byte if the queue was empty.
// Reset (aresetn low, synchronous): lexer idle, offsets zero, token queue empty.
`include "assert_macros.svh"

module source_byte_lexer #(
    parameter int POS_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  slx_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output slx_pkg::out_word_t m_data
);

    // Lexer state: mode of the pending token, its kind, start and length,
    // plus the offset of the next byte of the text.
    slx_pkg::lex_mode_t     mode_reg,  mode_next;
    slx_pkg::kind_t         kind_reg,  kind_next;
    logic [POS_WIDTH-1:0]   start_reg, start_next;
    slx_pkg::len_t          len_reg,   len_next;
    logic [POS_WIDTH-1:0]   pos_reg,   pos_next;

    slx_pkg::slx_step_t     step;
    logic                   s_fire;
    logic                   m_fire;
    logic                   fin;

    // Token after this byte is absorbed or opened (before any flush).
    slx_pkg::kind_t         upd_kind;
    logic [POS_WIDTH-1:0]   upd_start;
    slx_pkg::len_t          upd_len;

    slx_pkg::out_word_t     closed_word;
    slx_pkg::out_word_t     flush_word;
    slx_pkg::out_word_t     push_data [2];
    logic [1:0]             push_n;
    logic                   q_room2;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;
    assign fin    = s_data.end_of_text;

    slx_classify u_classify (
        .mode_i (mode_reg),
        .kind_i (kind_reg),
        .text_i (s_data.text_byte),
        .step_o (step)
    );

    // Absorbing bumps the length (saturating); otherwise a fresh token
    // starts here with length one.
    assign upd_kind  = step.kind;
    assign upd_start = step.absorb ? start_reg : pos_reg;
    always_comb begin
        if (!step.absorb) begin
            upd_len = slx_pkg::len_t'(1);
        end else if (len_reg == slx_pkg::LEN_MAX) begin
            upd_len = len_reg;
        end else begin
            upd_len = len_reg + slx_pkg::len_t'(1);
        end
    end

    // The pending token as closed by a byte that cannot extend it.
    assign closed_word.tok_kind     = kind_reg;
    assign closed_word.start_offset = slx_pkg::offset_t'(start_reg);
    assign closed_word.token_length = len_reg;
    assign closed_word.last_token   = 1'b0;

    // The token flushed at end of text.
    assign flush_word.tok_kind      = upd_kind;
    assign flush_word.start_offset  = slx_pkg::offset_t'(upd_start);
    assign flush_word.token_length  = upd_len;
    assign flush_word.last_token    = 1'b1;

    // Closed token always goes first; a lone flush takes the first slot.
    assign push_data[0] = step.close ? closed_word : flush_word;
    assign push_data[1] = flush_word;
    always_comb begin
        if (!s_fire) begin
            push_n = 2'd0;
        end else begin
            push_n = 2'(step.close) + 2'(fin);
        end
    end

    // Next state; end of text returns everything to reset values.
    always_comb begin
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        start_next = start_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        if (s_fire) begin
            if (fin) begin
                mode_next  = slx_pkg::MODE_IDLE;
                kind_next  = slx_pkg::K_IDENT;
                start_next = '0;
                len_next   = '0;
                pos_next   = '0;
            end else begin
                mode_next  = step.mode;
                kind_next  = upd_kind;
                start_next = upd_start;
                len_next   = upd_len;
                pos_next   = pos_reg + POS_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= slx_pkg::MODE_IDLE;
            kind_reg  <= slx_pkg::K_IDENT;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            kind_reg  <= kind_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

    // Result queue decouples the two sides; a byte is taken whenever two
    // free slots remain, so a byte never blocks on the current m_ready.
    slx_token_fifo u_token_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push_data (push_data),
        .pop       (m_fire),
        .not_empty (m_valid),
        .room2     (q_room2),
        .head      (m_data)
    );

    assign s_ready = q_room2;

    // ---------------------------------------------------------------- checks
    `SLX_ASSERT_RST(a_flush_resets, aclk, aresetn,
        s_fire && fin |=> mode_reg == slx_pkg::MODE_IDLE && pos_reg == '0,
        "lexer not idle after end of text")
    `SLX_ASSERT_RST(a_byte_leaves_pending, aclk, aresetn,
        s_fire && !fin |=> mode_reg != slx_pkg::MODE_IDLE && len_reg != '0,
        "no pending token after a byte")
    `SLX_ASSERT_RST(a_token_shows, aclk, aresetn,
        s_fire && (step.close || fin) |=> m_valid,
        "closed or flushed token not presented")
    `SLX_ASSERT_ALWAYS(a_idle_len, aclk,
        !aresetn || ((mode_reg == slx_pkg::MODE_IDLE) == (len_reg == '0)),
        "pending length disagrees with lexer mode")

endmodule

/* rtl/core/slx_classify.sv */
// Byte classifier: decides extend or close, and the next mode and kind.
module slx_classify (
    input  slx_pkg::lex_mode_t mode_i,
    input  slx_pkg::kind_t     kind_i,
    input  logic [7:0]         text_i,
    output slx_pkg::slx_step_t step_o
);

    logic               ext;
    slx_pkg::lex_mode_t ext_mode;
    slx_pkg::kind_t     ext_kind;
    slx_pkg::lex_mode_t open_mode;
    slx_pkg::kind_t     open_kind;
    logic               alpha;
    logic               num;

    assign alpha = slx_pkg::is_alpha(text_i);
    assign num   = slx_pkg::is_num(text_i);

    // extension of the pending token
    always_comb begin
        ext      = 1'b0;
        ext_mode = mode_i;
        ext_kind = kind_i;
        unique case (mode_i)
            slx_pkg::MODE_IDENT: begin
                ext = alpha || num || (text_i == slx_pkg::CH_UNDERSCORE);
            end
            slx_pkg::MODE_INT: begin
                if (num) begin
                    ext = 1'b1;
                end else if (text_i == slx_pkg::CH_DOT) begin
                    ext      = 1'b1;
                    ext_mode = slx_pkg::MODE_REAL;
                    ext_kind = slx_pkg::K_REAL;
                end
            end
            slx_pkg::MODE_REAL: begin
                ext = num;
            end
            slx_pkg::MODE_DOT: begin
                if (num) begin
                    ext      = 1'b1;
                    ext_mode = slx_pkg::MODE_REAL;
                    ext_kind = slx_pkg::K_REAL;
                end
            end
            slx_pkg::MODE_SLASH: begin
                if (text_i == slx_pkg::CH_SLASH) begin
                    ext      = 1'b1;
                    ext_mode = slx_pkg::MODE_COMMENT;
                    ext_kind = slx_pkg::K_COMMENT;
                end
            end
            slx_pkg::MODE_COMMENT: begin
                ext = (text_i != slx_pkg::CH_NEWLINE);
            end
            slx_pkg::MODE_AMP: begin
                if (text_i == slx_pkg::CH_AMP) begin
                    ext      = 1'b1;
                    ext_mode = slx_pkg::MODE_FIXED;
                    ext_kind = slx_pkg::K_DAMP;
                end
            end
            slx_pkg::MODE_PIPE: begin
                if (text_i == slx_pkg::CH_PIPE) begin
                    ext      = 1'b1;
                    ext_mode = slx_pkg::MODE_FIXED;
                    ext_kind = slx_pkg::K_DPIPE;
                end
            end
            slx_pkg::MODE_BANG: begin
                if (text_i == slx_pkg::CH_EQUALS) begin
                    ext      = 1'b1;
                    ext_mode = slx_pkg::MODE_FIXED;
                    ext_kind = slx_pkg::K_BANGEQ;
                end
            end
            slx_pkg::MODE_EQ: begin
                if (text_i == slx_pkg::CH_EQUALS) begin
                    ext      = 1'b1;
                    ext_mode = slx_pkg::MODE_FIXED;
                    ext_kind = slx_pkg::K_DEQ;
                end
            end
            slx_pkg::MODE_LESS: begin
                if (text_i == slx_pkg::CH_EQUALS) begin
                    ext      = 1'b1;
                    ext_mode = slx_pkg::MODE_FIXED;
                    ext_kind = slx_pkg::K_LE;
                end
            end
            slx_pkg::MODE_GREATER: begin
                if (text_i == slx_pkg::CH_EQUALS) begin
                    ext      = 1'b1;
                    ext_mode = slx_pkg::MODE_FIXED;
                    ext_kind = slx_pkg::K_GE;
                end
            end
            slx_pkg::MODE_IDLE, slx_pkg::MODE_FIXED: begin
                ext = 1'b0;
            end
            default: begin
                ext = 1'b0;
            end
        endcase
    end

    // mode and kind of a token opened by this byte
    always_comb begin
        priority if (alpha || text_i == slx_pkg::CH_UNDERSCORE) begin
            open_mode = slx_pkg::MODE_IDENT;
            open_kind = slx_pkg::K_IDENT;
        end else if (num) begin
            open_mode = slx_pkg::MODE_INT;
            open_kind = slx_pkg::K_INT;
        end else if (text_i == slx_pkg::CH_DOT) begin
            open_mode = slx_pkg::MODE_DOT;
            open_kind = slx_pkg::K_DOT;
        end else if (text_i == slx_pkg::CH_SLASH) begin
            open_mode = slx_pkg::MODE_SLASH;
            open_kind = slx_pkg::K_SLASH;
        end else if (text_i == slx_pkg::CH_AMP) begin
            open_mode = slx_pkg::MODE_AMP;
            open_kind = slx_pkg::K_AMP;
        end else if (text_i == slx_pkg::CH_PIPE) begin
            open_mode = slx_pkg::MODE_PIPE;
            open_kind = slx_pkg::K_PIPE;
        end else if (text_i == slx_pkg::CH_BANG) begin
            open_mode = slx_pkg::MODE_BANG;
            open_kind = slx_pkg::K_BANG;
        end else if (text_i == slx_pkg::CH_EQUALS) begin
            open_mode = slx_pkg::MODE_EQ;
            open_kind = slx_pkg::K_EQ;
        end else if (text_i == slx_pkg::CH_LESS) begin
            open_mode = slx_pkg::MODE_LESS;
            open_kind = slx_pkg::K_LT;
        end else if (text_i == slx_pkg::CH_GREATER) begin
            open_mode = slx_pkg::MODE_GREATER;
            open_kind = slx_pkg::K_GT;
        end else begin
            open_mode = slx_pkg::MODE_FIXED;
            open_kind = slx_pkg::single_kind(text_i);
        end
    end

    assign step_o.absorb = ext;
    assign step_o.close  = (mode_i != slx_pkg::MODE_IDLE) && !ext;
    assign step_o.mode   = ext ? ext_mode : open_mode;
    assign step_o.kind   = ext ? ext_kind : open_kind;

endmodule

/* rtl/core/slx_token_fifo.sv */
// Small token queue: takes up to two words per cycle, hands out one.
module slx_token_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          push_n,
    input  slx_pkg::out_word_t  push_data [2],
    input  logic                pop,
    output logic                not_empty,
    output logic                room2,
    output slx_pkg::out_word_t  head
);

    slx_pkg::out_word_t q_reg [slx_pkg::Q_DEPTH];
    slx_pkg::qptr_t     wr_ptr_reg, wr_ptr_next;
    slx_pkg::qptr_t     rd_ptr_reg, rd_ptr_next;
    slx_pkg::qcnt_t     count_reg, count_next;

    assign wr_ptr_next = wr_ptr_reg + slx_pkg::qptr_t'(push_n);
    assign rd_ptr_next = rd_ptr_reg + slx_pkg::qptr_t'(pop);
    assign count_next  = count_reg + slx_pkg::qcnt_t'(push_n) - slx_pkg::qcnt_t'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_reg + slx_pkg::qptr_t'(1)] <= push_data[1];
        end
    end

    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= slx_pkg::qcnt_t'(slx_pkg::Q_DEPTH - 2));
    assign head      = q_reg[rd_ptr_reg];

endmodule
